[design/uds_security_access_responder_core_macros.svh]
// Assertion helpers shared by the responder files.
// Both forms sample on clk and are switched off while arst_n is low.
`ifndef UDS_SECURITY_ACCESS_RESPONDER_CORE_MACROS_SVH
`define UDS_SECURITY_ACCESS_RESPONDER_CORE_MACROS_SVH

// Same-cycle implication
`define UDSSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define UDSSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/udssa_pkg.sv]
package udssa_pkg;

	// Service and subfunction codes
	localparam logic [7:0] SID_SEC_ACCESS   = 8'h27;
	localparam logic [7:0] SID_READ_DTC     = 8'h19;
	localparam logic [7:0] SUB_REQ_SEED     = 8'h01;
	localparam logic [7:0] SUB_SEND_KEY     = 8'h02;
	localparam logic [7:0] SUB_DTC_BY_MASK  = 8'h02;

	// Response codes
	localparam logic [7:0] RSP_SEC_ACCESS   = 8'h67;
	localparam logic [7:0] RSP_READ_DTC     = 8'h59;
	localparam logic [7:0] RSP_NEGATIVE     = 8'h7F;
	localparam logic [7:0] NRC_INVALID_KEY  = 8'h35;
	localparam logic [7:0] NRC_SEQ_ERROR    = 8'h24;
	localparam logic [7:0] DTC_AVAIL_MASK   = 8'h01;
	localparam logic [23:0] DTC_OVER_TEMP   = 24'h9A0115;
	localparam logic [7:0] DTC_STATUS       = 8'h09;
	localparam logic [31:0] FAULT_OVER_TEMP = 32'd2;

	// PCI bytes and lengths of the responses
	localparam logic [7:0] PCI_SEED         = 8'h06;
	localparam logic [7:0] PCI_KEY_OK       = 8'h02;
	localparam logic [7:0] PCI_NEGATIVE     = 8'h03;
	localparam logic [7:0] PCI_DTC_NONE     = 8'h03;
	localparam logic [7:0] PCI_DTC_ONE      = 8'h07;
	localparam logic [3:0] LEN_SEED         = 4'd7;
	localparam logic [3:0] LEN_KEY_OK       = 4'd3;
	localparam logic [3:0] LEN_NEGATIVE     = 4'd4;
	localparam logic [3:0] LEN_DTC_NONE     = 4'd4;
	localparam logic [3:0] LEN_DTC_ONE      = 4'd8;

	// FNV-1a 32-bit
	localparam logic [31:0] FNV_BASIS       = 32'd2166136261;
	localparam logic [31:0] FNV_MULT        = 32'd16777619;

	// Register map
	localparam logic [31:0] SEED_RESET      = 32'h12345678;
	localparam logic        REG_SEED_VALUE  = 1'b0;

	typedef enum logic [1:0] {
		SEC_LOCKED    = 2'd0,
		SEC_SEED_SENT = 2'd1,
		SEC_UNLOCKED  = 2'd2
	} sec_state_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_HASH,
		ST_OUT
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic       capture;
		logic       hash_init;
		logic       hash_step;
		logic [1:0] hash_idx;
		logic       commit;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic has_resp;
		logic is_seed;
	} dp_sts_t;

endpackage

[design/udssa_req_if.sv]
interface udssa_req_if;
	logic        valid;
	logic        ready;
	logic [6:0]  frame_len;
	logic [7:0]  pci_len;
	logic [7:0]  service_id;
	logic [7:0]  sub_function;
	logic [31:0] tester_key;
	logic [31:0] fault_code;

	modport source (
		output valid, frame_len, pci_len, service_id, sub_function, tester_key, fault_code,
		input  ready
	);
	modport sink (
		input  valid, frame_len, pci_len, service_id, sub_function, tester_key, fault_code,
		output ready
	);
endinterface

[design/udssa_resp_if.sv]
interface udssa_resp_if;
	logic        valid;
	logic        ready;
	logic [3:0]  resp_len;
	logic [63:0] resp_bytes;
	logic [1:0]  security_level;

	modport source (
		output valid, resp_len, resp_bytes, security_level,
		input  ready
	);
	modport sink (
		input  valid, resp_len, resp_bytes, security_level,
		output ready
	);
endinterface

[design/udssa_ctrl.sv]
module udssa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  udssa_pkg::dp_sts_t sts,
	output udssa_pkg::dp_cmd_t cmd
);
	import udssa_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [1:0]  cnt_q, cnt_d;
	logic        out_valid_q;
	logic        out_free;

	// Result register free once its beat is taken
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.commit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		cnt_d         = cnt_q;
		in_ready      = 1'b0;
		cmd           = '0;
		cmd.hash_idx  = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (!sts.has_resp) begin
					state_d = ST_IDLE;
				end else if (sts.is_seed) begin
					cmd.hash_init = 1'b1;
					cnt_d         = 2'd0;
					state_d       = ST_HASH;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_HASH: begin
				// one seed byte per cycle, least significant first
				cmd.hash_step = 1'b1;
				cnt_d         = cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[design/udssa_dp.sv]
module udssa_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  udssa_pkg::dp_cmd_t cmd,
	output udssa_pkg::dp_sts_t sts,
	input  logic [31:0]        seed_value,
	input  logic [6:0]         frame_len,
	input  logic [7:0]         pci_len,
	input  logic [7:0]         service_id,
	input  logic [7:0]         sub_function,
	input  logic [31:0]        tester_key,
	input  logic [31:0]        fault_code,
	output logic [3:0]         resp_len,
	output logic [63:0]        resp_bytes,
	output logic [1:0]         security_level
);
	import udssa_pkg::*;

	logic [6:0]  flen_q;
	logic [7:0]  pci_q, sid_q, sub_q;
	logic [31:0] key_q, fault_q;
	logic [31:0] h_q, h_next;
	logic [7:0]  seed_byte;
	sec_state_t  sec_q, sec_d;
	logic [31:0] exp_key_q;
	logic [3:0]  len_q, len_d;
	logic [63:0] bytes_q, bytes_d;
	logic [7:0]  sub_eff;
	logic [31:0] key_eff;
	logic        frame_ok;

	// Frame capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			flen_q  <= frame_len;
			pci_q   <= pci_len;
			sid_q   <= service_id;
			sub_q   <= sub_function;
			key_q   <= tester_key;
			fault_q <= fault_code;
		end
	end

	// Length checks; bytes past the frame read as zero
	assign frame_ok = (flen_q >= 7'd2) && (pci_q <= (8'(flen_q) - 8'd1));
	assign sub_eff  = (flen_q >= 7'd3) ? sub_q : 8'h00;
	assign key_eff  = {
		(flen_q > 7'd3) ? key_q[31:24] : 8'h00,
		(flen_q > 7'd4) ? key_q[23:16] : 8'h00,
		(flen_q > 7'd5) ? key_q[15:8]  : 8'h00,
		(flen_q > 7'd6) ? key_q[7:0]   : 8'h00
	};

	assign sts.is_seed  = (sid_q == SID_SEC_ACCESS) && (sub_eff == SUB_REQ_SEED);
	assign sts.has_resp = frame_ok && (
		((sid_q == SID_SEC_ACCESS) &&
			((sub_eff == SUB_REQ_SEED) || (sub_eff == SUB_SEND_KEY))) ||
		((sid_q == SID_READ_DTC) && (sub_eff == SUB_DTC_BY_MASK)));

	// FNV-1a: xor one seed byte, multiply by the prime
	assign seed_byte = 8'(seed_value >> {cmd.hash_idx, 3'b000});
	assign h_next    = 32'((h_q ^ {24'h000000, seed_byte}) * FNV_MULT);

	always_ff @(posedge clk) begin
		if (cmd.hash_init)
			h_q <= FNV_BASIS;
		else if (cmd.hash_step)
			h_q <= h_next;
	end

	// Response and next security state
	always_comb begin
		sec_d   = sec_q;
		len_d   = LEN_NEGATIVE;
		bytes_d = '0;
		unique case (sid_q)
			SID_SEC_ACCESS: begin
				if (sts.is_seed) begin
					sec_d   = SEC_SEED_SENT;
					len_d   = LEN_SEED;
					bytes_d = {PCI_SEED, RSP_SEC_ACCESS, SUB_REQ_SEED, seed_value, 8'h00};
				end else if (sec_q == SEC_SEED_SENT) begin
					if (key_eff == exp_key_q) begin
						sec_d   = SEC_UNLOCKED;
						len_d   = LEN_KEY_OK;
						bytes_d = {PCI_KEY_OK, RSP_SEC_ACCESS, SUB_SEND_KEY, 40'h0};
					end else begin
						bytes_d = {PCI_NEGATIVE, RSP_NEGATIVE, SID_SEC_ACCESS,
							NRC_INVALID_KEY, 32'h0};
					end
				end else begin
					bytes_d = {PCI_NEGATIVE, RSP_NEGATIVE, SID_SEC_ACCESS,
						NRC_SEQ_ERROR, 32'h0};
				end
			end
			default: begin
				// read DTC, the only other service that reaches commit
				if (fault_q == FAULT_OVER_TEMP) begin
					len_d   = LEN_DTC_ONE;
					bytes_d = {PCI_DTC_ONE, RSP_READ_DTC, SUB_DTC_BY_MASK, DTC_AVAIL_MASK,
						DTC_OVER_TEMP, DTC_STATUS};
				end else begin
					len_d   = LEN_DTC_NONE;
					bytes_d = {PCI_DTC_NONE, RSP_READ_DTC, SUB_DTC_BY_MASK, DTC_AVAIL_MASK,
						32'h0};
				end
			end
		endcase
	end

	// Security state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q     <= SEC_LOCKED;
			exp_key_q <= 32'h0;
		end else if (cmd.commit) begin
			sec_q <= sec_d;
			if (sts.is_seed)
				exp_key_q <= h_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			len_q   <= len_d;
			bytes_q <= bytes_d;
		end
	end

	assign resp_len       = len_q;
	assign resp_bytes     = bytes_q;
	assign security_level = sec_q;
endmodule

[design/uds_security_access_responder_core.sv]
// Channel   Dir  Beat contents
// req       in   frame_len, pci_len, service_id, sub_function, tester_key, fault_code
// resp      out  resp_len, resp_bytes, security_level
// apb       in   seed_value at byte address 0
//
// One frame at a time: each is captured, decoded and, for a request seed, hashed
// before its response, if any, is committed; the FNV-1a hash takes one seed byte per
// cycle through a single 32x32 multiplier.
// arst_n locks the security level, clears the expected key and returns the seed
// register to 0x12345678.
// A response waiting on resp does not block the next req beat; only the final
// commit of that next frame waits for the result register to empty.
`include "uds_security_access_responder_core_macros.svh"

module uds_security_access_responder_core (
	input  logic         clk,
	input  logic         arst_n,
	udssa_req_if.sink    req,
	udssa_resp_if.source resp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	import udssa_pkg::*;

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [31:0] seed_q;
	logic        sel_seed;

	// Register port
	assign pready   = 1'b1;
	assign sel_seed = (paddr[2] == REG_SEED_VALUE);
	assign prdata   = sel_seed ? seed_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seed_q <= SEED_RESET;
		else if (psel && penable && pwrite && sel_seed)
			seed_q <= pwdata;
	end

	udssa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (resp.valid),
		.out_ready (resp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	udssa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.seed_value     (seed_q),
		.frame_len      (req.frame_len),
		.pci_len        (req.pci_len),
		.service_id     (req.service_id),
		.sub_function   (req.sub_function),
		.tester_key     (req.tester_key),
		.fault_code     (req.fault_code),
		.resp_len       (resp.resp_len),
		.resp_bytes     (resp.resp_bytes),
		.security_level (resp.security_level)
	);

	// Checks
	`UDSSA_ASSERT_NEXT(a_one_frame, req.valid && req.ready, !req.ready,
		"second frame taken while one is in decode")
	`UDSSA_ASSERT_SAME(a_len_legal, resp.valid,
		resp.resp_len == LEN_KEY_OK || resp.resp_len == LEN_NEGATIVE ||
		resp.resp_len == LEN_SEED || resp.resp_len == LEN_DTC_ONE,
		"illegal response length")
	`UDSSA_ASSERT_SAME(a_unlock_resp, resp.valid && resp.resp_len == LEN_KEY_OK,
		resp.security_level == SEC_UNLOCKED,
		"positive key response without unlock")
	`UDSSA_ASSERT_SAME(a_commit_busy, $rose(resp.valid), $past(!req.ready),
		"response raised without a frame in progress")
endmodule

[tb/uds_security_access_responder_core_checker.sv]
`timescale 1ns / 1ps

module uds_security_access_responder_core_checker (
	input  logic        clk,
	input  logic        arst_n,
	udssa_req_if        req,
	udssa_resp_if       resp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          fail_count,
	output int          pending,
	output logic [31:0] unlock_key
);
	import udssa_pkg::*;

	localparam logic [2:0] SEED_ADDR = 3'(4 * REG_SEED_VALUE);

	typedef struct packed {
		logic [3:0]  len;
		logic [63:0] bytes;
		logic [1:0]  level;
	} reply_t;

	// Shadow of the responder's register and security state
	logic [31:0] seed_reg;
	sec_state_t  sec_level;
	logic [31:0] key_due;
	reply_t      replies_due [$];

	assign unlock_key = key_due;

	// 32-bit FNV-1a over the seed, low byte first
	function automatic logic [31:0] seed_hash(input logic [31:0] s);
		logic [31:0] h;
		h = FNV_BASIS;
		for (int i = 0; i < 4; i++) begin
			h = (h ^ {24'd0, s[8 * i +: 8]}) * FNV_MULT;
		end
		return h;
	endfunction

	// Works out the reply to one frame and moves the security state on.
	// Returns 0 where the frame gets no reply.
	function automatic bit answer_frame(input logic [6:0] flen, input logic [7:0] pci,
			input logic [7:0] sid, input logic [7:0] sub_in, input logic [31:0] key_in,
			input logic [31:0] fault, output reply_t r);
		logic [7:0]  b [8];
		logic [7:0]  sub;
		logic [31:0] key;
		logic [3:0]  n;
		r = '0;
		foreach (b[i]) b[i] = 8'h00;
		n = 4'd0;
		// too short, or PCI length runs past the bytes received
		if (flen < 7'd2 || int'(pci) > int'(flen) - 1)
			return 1'b0;
		// bytes beyond the frame length read as zero
		sub = (flen < 7'd3) ? 8'h00 : sub_in;
		key = key_in;
		for (int k = 3; k < 7; k++) begin
			if (k >= int'(flen))
				key[8 * (6 - k) +: 8] = 8'h00;
		end

		if (sid == SID_SEC_ACCESS) begin
			if (sub == SUB_REQ_SEED) begin
				key_due   = seed_hash(seed_reg);
				sec_level = SEC_SEED_SENT;
				b[0] = PCI_SEED;
				b[1] = RSP_SEC_ACCESS;
				b[2] = SUB_REQ_SEED;
				{b[3], b[4], b[5], b[6]} = seed_reg;
				n = LEN_SEED;
			end else if (sub == SUB_SEND_KEY) begin
				if (sec_level == SEC_SEED_SENT && key == key_due) begin
					sec_level = SEC_UNLOCKED;
					b[0] = PCI_KEY_OK;
					b[1] = RSP_SEC_ACCESS;
					b[2] = SUB_SEND_KEY;
					n = LEN_KEY_OK;
				end else begin
					// wrong key after a seed, otherwise out of sequence
					b[0] = PCI_NEGATIVE;
					b[1] = RSP_NEGATIVE;
					b[2] = SID_SEC_ACCESS;
					b[3] = (sec_level == SEC_SEED_SENT) ? NRC_INVALID_KEY : NRC_SEQ_ERROR;
					n = LEN_NEGATIVE;
				end
			end
		end else if (sid == SID_READ_DTC && sub == SUB_DTC_BY_MASK) begin
			b[0] = PCI_DTC_NONE;
			b[1] = RSP_READ_DTC;
			b[2] = SUB_DTC_BY_MASK;
			b[3] = DTC_AVAIL_MASK;
			n = LEN_DTC_NONE;
			if (fault == FAULT_OVER_TEMP) begin
				b[0] = PCI_DTC_ONE;
				{b[4], b[5], b[6]} = DTC_OVER_TEMP;
				b[7] = DTC_STATUS;
				n = LEN_DTC_ONE;
			end
		end

		if (n == 4'd0)
			return 1'b0;
		r.len   = n;
		r.bytes = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
		r.level = sec_level;
		return 1'b1;
	endfunction

	// Monitor: register port, result beats, then request beats
	always @(posedge clk or negedge arst_n) begin
		reply_t got;
		reply_t want;
		reply_t fresh;
		if (!arst_n) begin
			seed_reg  = SEED_RESET;
			sec_level = SEC_LOCKED;
			key_due   = '0;
			replies_due.delete();
			pending   = 0;
		end else begin
			// register access
			if (psel && penable && pready && paddr == SEED_ADDR) begin
				if (pwrite) begin
					seed_reg = pwdata;
				end else if (prdata !== seed_reg) begin
					fail_count++;
					$error("prdata: expected %h, got %h", seed_reg, prdata);
				end
			end

			// result beat against the oldest expectation
			if (resp.valid && resp.ready) begin
				got.len   = resp.resp_len;
				got.bytes = resp.resp_bytes;
				got.level = resp.security_level;
				if (replies_due.size() == 0) begin
					fail_count++;
					$error("unexpected result beat: len %0d bytes %h level %0d",
						got.len, got.bytes, got.level);
				end else begin
					want = replies_due.pop_front();
					if (got.len !== want.len) begin
						fail_count++;
						$error("resp_len: expected %0d, got %0d", want.len, got.len);
					end
					if (got.bytes !== want.bytes) begin
						fail_count++;
						$error("resp_bytes: expected %h, got %h", want.bytes, got.bytes);
					end
					if (got.level !== want.level) begin
						fail_count++;
						$error("security_level: expected %0d, got %0d", want.level, got.level);
					end
				end
			end

			// request beat
			if (req.valid && req.ready) begin
				if (answer_frame(req.frame_len, req.pci_len, req.service_id, req.sub_function,
						req.tester_key, req.fault_code, fresh))
					replies_due.push_back(fresh);
			end
			pending = replies_due.size();
		end
	end

endmodule

[tb/uds_security_access_responder_core_tb.sv]
`timescale 1ns / 1ps

module uds_security_access_responder_core_tb;
	import udssa_pkg::*;

	localparam int         PHASES         = 5;
	localparam int         FRAMES_PER_PH  = 268;
	localparam int         SETTLE_CYCLES  = 12;
	localparam int         LONG_HOLD      = 300;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam logic [2:0] SEED_ADDR      = 3'(4 * REG_SEED_VALUE);
	localparam logic [2:0] SPARE_ADDR     = 3'(4 * (REG_SEED_VALUE + 1));
	localparam logic [7:0] SID_UNUSED     = 8'h3E;
	localparam logic [7:0] SUB_UNUSED     = 8'h03;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int          fail_count;
	int          pending;
	logic [31:0] unlock_key;

	int          idle_pct;
	bit          calm;
	bit          hold_resp;
	int          stall_cycles;

	udssa_req_if  req_bus ();
	udssa_resp_if resp_bus ();

	uds_security_access_responder_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.resp    (resp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	uds_security_access_responder_core_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_bus),
		.resp       (resp_bus),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending),
		.unlock_key (unlock_key)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Result side: random stalls, and one long hold-off when asked
	initial begin
		int stall_left;
		stall_left = 0;
		resp_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_resp) begin
				hold_resp  = 1'b0;
				stall_left = LONG_HOLD;
			end
			if (stall_left > 0) begin
				stall_left--;
				resp_bus.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < idle_pct) begin
				stall_left = $urandom_range(0, 14);
				resp_bus.ready <= 1'b0;
			end else begin
				resp_bus.ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles with no beat on any port
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (resp_bus.valid && resp_bus.ready)
				|| (psel && penable)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("[uds_security_access_responder_core] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// One frame beat; called and returns at a falling edge
	task automatic send_frame(input logic [6:0] flen, input logic [7:0] pci,
			input logic [7:0] sid, input logic [7:0] sub, input logic [31:0] key,
			input logic [31:0] fault);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		req_bus.valid        <= 1'b1;
		req_bus.frame_len    <= flen;
		req_bus.pci_len      <= pci;
		req_bus.service_id   <= sid;
		req_bus.sub_function <= sub;
		req_bus.tester_key   <= key;
		req_bus.fault_code   <= fault;
		do @(posedge clk); while (!req_bus.ready);
		@(negedge clk);
	endtask

	// Stop offering and wait for every outstanding reply, then let the block go idle
	task automatic drain_results();
		req_bus.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Setup phase and access phase, then the bus returns to idle
	task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// Half the time a classic 7- or 8-byte frame, otherwise any length from lo up to the 7-bit limit
	function automatic logic [6:0] pick_len(input int unsigned lo);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 7'($urandom_range(65, 127));
		if (r < 6)
			return 7'($urandom_range(7, 8));
		return 7'($urandom_range(lo, 64));
	endfunction

	function automatic logic [7:0] pick_pci(input logic [6:0] flen);
		int unsigned r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'(flen - 1);
		return 8'($urandom_range(0, int'(flen) - 1));
	endfunction

	// One random frame or an unlock sequence; counted is low for the unsupported and noise frames
	task automatic send_random_frame(output bit counted);
		int unsigned pick;
		logic [6:0]  flen;
		logic [7:0]  sid;
		logic [7:0]  sub;
		pick    = $urandom_range(0, 99);
		counted = 1'b1;
		if (pick < 22) begin
			flen = pick_len(3);
			send_frame(flen, pick_pci(flen), SID_SEC_ACCESS, SUB_REQ_SEED, $urandom, $urandom);
		end else if (pick < 40) begin
			// seed request followed by the matching key
			send_frame(7'd8, 8'd7, SID_SEC_ACCESS, SUB_REQ_SEED, $urandom, $urandom);
			flen = pick_len(7);
			send_frame(flen, pick_pci(flen), SID_SEC_ACCESS, SUB_SEND_KEY, unlock_key, $urandom);
		end else if (pick < 52) begin
			flen = pick_len(7);
			send_frame(flen, pick_pci(flen), SID_SEC_ACCESS, SUB_SEND_KEY, unlock_key, $urandom);
		end else if (pick < 64) begin
			// near miss or random key, frames now and then cut short
			flen = pick_len(3);
			send_frame(flen, pick_pci(flen), SID_SEC_ACCESS, SUB_SEND_KEY,
				pick[0] ? $urandom : unlock_key ^ (32'd1 << $urandom_range(0, 31)), $urandom);
		end else if (pick < 82) begin
			flen = pick_len(3);
			send_frame(flen, pick_pci(flen), SID_READ_DTC, SUB_DTC_BY_MASK, $urandom,
				$urandom_range(0, 1) ? FAULT_OVER_TEMP : $urandom);
		end else if (pick < 88) begin
			// well-formed but unsupported
			counted = 1'b0;
			flen = pick_len(3);
			sid  = pick[0] ? SID_UNUSED : SID_SEC_ACCESS;
			sub  = pick[0] ? SUB_REQ_SEED : SUB_UNUSED;
			send_frame(flen, pick_pci(flen), sid, sub, $urandom, $urandom);
		end else begin
			// noise: broken lengths and random codes
			counted = 1'b0;
			flen = pick[0] ? 7'($urandom_range(0, 3)) : 7'($urandom_range(0, 127));
			case ($urandom_range(0, 2))
				0: sid = SID_SEC_ACCESS;
				1: sid = SID_READ_DTC;
				default: sid = 8'($urandom);
			endcase
			sub = $urandom_range(0, 1) ? 8'($urandom_range(1, 2)) : 8'($urandom);
			send_frame(flen, 8'($urandom), sid, sub, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [31:0] seeds [PHASES];
		int          idle_by_phase [PHASES];
		int          done;
		bit          counted;
		seeds         = '{SEED_RESET, 32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom};
		idle_by_phase = '{20, 0, 30, 10, 0};

		req_bus.valid        = 1'b0;
		req_bus.frame_len    = '0;
		req_bus.pci_len      = '0;
		req_bus.service_id   = '0;
		req_bus.sub_function = '0;
		req_bus.tester_key   = '0;
		req_bus.fault_code   = '0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		idle_pct  = 0;
		calm      = 1'b0;
		hold_resp = 1'b0;
		arst_n    = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset value of the seed
		apb_access(1'b0, SEED_ADDR, '0);

		// Directed frames at the reset seed
		idle_pct = 15;
		send_frame(7'd0, 8'd0, SID_READ_DTC, SUB_DTC_BY_MASK, '0, FAULT_OVER_TEMP);
		send_frame(7'd1, 8'd0, SID_READ_DTC, SUB_DTC_BY_MASK, '0, FAULT_OVER_TEMP);
		send_frame(7'd2, 8'd1, SID_READ_DTC, SUB_DTC_BY_MASK, '0, FAULT_OVER_TEMP);
		send_frame(7'd2, 8'd2, SID_READ_DTC, SUB_DTC_BY_MASK, '0, FAULT_OVER_TEMP);
		send_frame(7'd8, 8'd7, SID_SEC_ACCESS, SUB_SEND_KEY, 32'hFFFF_FFFF, '0);
		send_frame(7'd3, 8'd2, SID_SEC_ACCESS, SUB_REQ_SEED, '0, '0);
		send_frame(7'd7, 8'd6, SID_SEC_ACCESS, SUB_SEND_KEY, ~unlock_key, '0);
		send_frame(7'd4, 8'd3, SID_SEC_ACCESS, SUB_SEND_KEY, unlock_key, '0);
		send_frame(7'd7, 8'd0, SID_SEC_ACCESS, SUB_SEND_KEY, unlock_key, '0);
		send_frame(7'd8, 8'd7, SID_SEC_ACCESS, SUB_SEND_KEY, unlock_key, '0);
		send_frame(7'd64, 8'd63, SID_SEC_ACCESS, SUB_REQ_SEED, 32'hFFFF_FFFF, '0);
		send_frame(7'd127, 8'd126, SID_SEC_ACCESS, SUB_SEND_KEY, unlock_key, 32'hFFFF_FFFF);
		send_frame(7'd127, 8'd255, SID_READ_DTC, SUB_DTC_BY_MASK, '0, FAULT_OVER_TEMP);
		send_frame(7'd8, 8'd7, SID_READ_DTC, SUB_DTC_BY_MASK, 32'hFFFF_FFFF, FAULT_OVER_TEMP);
		send_frame(7'd3, 8'd2, SID_READ_DTC, SUB_DTC_BY_MASK, '0, '0);
		send_frame(7'd8, 8'd7, SID_READ_DTC, SUB_DTC_BY_MASK, '0, 32'h8000_0002);
		send_frame(7'd8, 8'd7, SID_UNUSED, SUB_DTC_BY_MASK, '0, FAULT_OVER_TEMP);
		send_frame(7'd8, 8'd7, SID_SEC_ACCESS, SUB_UNUSED, '0, '0);
		send_frame(7'd8, 8'd7, SID_READ_DTC, SUB_REQ_SEED, '0, FAULT_OVER_TEMP);
		send_frame(7'd6, 8'd5, SID_SEC_ACCESS, SUB_REQ_SEED, '0, '0);
		send_frame(7'd2, 8'd1, SID_SEC_ACCESS, SUB_SEND_KEY, unlock_key, '0);
		send_frame(7'd5, 8'd4, SID_SEC_ACCESS, SUB_SEND_KEY, 32'hFFFF_FFFF, '0);

		// Random phases, a new seed between each
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_results();
				apb_access(1'b1, SEED_ADDR, seeds[ph]);
				apb_access(1'b0, SEED_ADDR, '0);
			end
			if (ph == 2) begin
				// unmapped register: the seed must not move
				apb_access(1'b1, SPARE_ADDR, $urandom);
				apb_access(1'b0, SEED_ADDR, '0);
			end
			calm     = (ph == PHASES - 1);
			idle_pct = idle_by_phase[ph];
			done     = 0;
			while (done < FRAMES_PER_PH) begin
				send_random_frame(counted);
				if (counted) begin
					done++;
					// long hold-off on the result side so the input backs up
					if (ph == 2 && done == 60)
						hold_resp = 1'b1;
					// sender waits until every reply is out
					if (ph == 3 && done == 120)
						drain_results();
				end
			end
		end

		drain_results();
		if (fail_count == 0) begin
			$display("[uds_security_access_responder_core] OK");
		end else begin
			$display("[uds_security_access_responder_core] ERROR");
		end
		$finish;
	end

endmodule
